>>> rtl/trc_pkg.sv
// ----------------------------------------------------------------------------
// Transitive closure engine package
// Shared widths and defaults of the reachability closure block.
// ----------------------------------------------------------------------------
package trc_pkg;

  localparam int unsigned ROW_W            = 32;
  localparam int unsigned CFG_W            = 6;
  localparam int unsigned IDX_W            = 5;
  localparam int unsigned MAX_VERTICES_DEF = 32;

  localparam logic [CFG_W-1:0] VERTEX_COUNT_RST = CFG_W'(32);

endpackage

>>> rtl/transitive_closure_engine.sv
// ----------------------------------------------------------------------------
// Transitive closure engine
// Loads an adjacency matrix row by row, closes it with Warshall's algorithm
// on a single row-wide OR unit, then streams out the reachability rows.
// ----------------------------------------------------------------------------
//
//   channel  | direction | signals                                  | beat
//   ---------+-----------+------------------------------------------+--------------
//   config   | in        | cfg_we_i, cfg_wdata_i                    | one write
//   input    | in        | in_valid_i/in_ready_o, adjacency_row_i   | one row
//   output   | out       | out_valid_o/out_ready_i, reach_row_o,    | one closure row
//            |           | row_index_o, last_row_o                  |
//
// Loading takes one input beat per cycle. After the last row the sequencer
// runs n pivot passes through the single memory read port and OR unit, then reads
// each row (S_ERD) and loads it into the output register (S_EOUT). A stalled
// output register holds the emitter; input beats are taken again once the last
// row sits in the output register. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module transitive_closure_engine #(
  parameter int unsigned MAX_VERTICES = trc_pkg::MAX_VERTICES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [trc_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [trc_pkg::ROW_W-1:0]  adjacency_row_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [trc_pkg::ROW_W-1:0]  reach_row_o,
  output logic [trc_pkg::IDX_W-1:0]  row_index_o,
  output logic                       last_row_o
);
  import trc_pkg::*;

  localparam int unsigned CAP = (MAX_VERTICES < ROW_W) ? MAX_VERTICES : ROW_W;
  localparam int unsigned AW  = $clog2(MAX_VERTICES);
  localparam int unsigned CW  = $clog2(CAP + 1);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_PRD  = 3'd1;
  localparam logic [2:0] S_PLAT = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_ERD  = 3'd4;
  localparam logic [2:0] S_EOUT = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CFG_W-1:0] vc_q;
  logic [CW-1:0]    load_cnt_q, load_cnt_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    piv_q, piv_d;
  logic [ROW_W-1:0] piv_bit_q, piv_bit_d;
  logic [ROW_W-1:0] pivot_q, pivot_d;
  logic [ROW_W-1:0] rd_data_q;
  logic [AW-1:0]    rd_addr, rd_addr_q;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [ROW_W-1:0] mem_wdata;
  logic [ROW_W-1:0] mem [MAX_VERTICES];

  logic             out_load;
  logic             out_valid_q;
  logic [ROW_W-1:0] reach_row_q;
  logic [IDX_W-1:0] row_index_q;
  logic             last_row_q;

  logic [CW-1:0]    n_w;
  logic [ROW_W:0]   mask_ext;
  logic [ROW_W-1:0] row_mask;

  always_comb begin
    if (vc_q == '0) begin
      n_w = CW'(1);
    end else if (vc_q > CFG_W'(CAP)) begin
      n_w = CW'(CAP);
    end else begin
      n_w = CW'(vc_q);
    end
  end

  assign mask_ext = ({{ROW_W{1'b0}}, 1'b1} << n_w) - 1'b1;
  assign row_mask = mask_ext[ROW_W-1:0];

  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    cnt_d      = cnt_q;
    piv_d      = piv_q;
    piv_bit_d  = piv_bit_q;
    pivot_d    = pivot_q;
    rd_addr    = rd_addr_q;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    out_load   = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mem_we    = 1'b1;
          mem_waddr = load_cnt_q[AW-1:0];
          mem_wdata = adjacency_row_i & row_mask;
          if (CW'(load_cnt_q + 1'b1) == n_w) begin
            load_cnt_d = '0;
            piv_d      = '0;
            piv_bit_d  = ROW_W'(1);
            state_d    = S_PRD;
          end else begin
            load_cnt_d = load_cnt_q + 1'b1;
          end
        end
      end
      S_PRD: begin
        rd_addr = piv_q[AW-1:0];
        state_d = S_PLAT;
      end
      S_PLAT: begin
        pivot_d = rd_data_q;
        cnt_d   = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (cnt_q != n_w) begin
          rd_addr = cnt_q[AW-1:0];
        end
        if ((cnt_q != '0) && (|(rd_data_q & piv_bit_q))) begin
          mem_we    = 1'b1;
          mem_waddr = rd_addr_q;
          mem_wdata = rd_data_q | pivot_q;
        end
        if (cnt_q == n_w) begin
          cnt_d = '0;
          if (CW'(piv_q + 1'b1) == n_w) begin
            state_d = S_ERD;
          end else begin
            piv_d     = piv_q + 1'b1;
            piv_bit_d = piv_bit_q << 1;
            state_d   = S_PRD;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_ERD: begin
        rd_addr = cnt_q[AW-1:0];
        state_d = S_EOUT;
      end
      S_EOUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          if (CW'(cnt_q + 1'b1) == n_w) begin
            cnt_d   = '0;
            state_d = S_LOAD;
          end else begin
            cnt_d   = cnt_q + 1'b1;
            state_d = S_ERD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      vc_q        <= VERTEX_COUNT_RST;
      load_cnt_q  <= '0;
      cnt_q       <= '0;
      piv_q       <= '0;
      piv_bit_q   <= ROW_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      piv_q     <= piv_d;
      piv_bit_q <= piv_bit_d;
      if (cfg_we_i) begin
        vc_q       <= cfg_wdata_i;
        load_cnt_q <= '0;
      end else begin
        load_cnt_q <= load_cnt_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem[rd_addr];
    rd_addr_q <= rd_addr;
    pivot_q   <= pivot_d;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      reach_row_q <= rd_data_q & row_mask;
      row_index_q <= IDX_W'(cnt_q);
      last_row_q  <= (CW'(cnt_q + 1'b1) == n_w);
    end
  end

  assign out_valid_o = out_valid_q;
  assign reach_row_o = reach_row_q;
  assign row_index_o = row_index_q;
  assign last_row_o  = last_row_q;

`ifndef SYNTHESIS
  a_piv_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(piv_bit_q))
    else $error("pivot select is not one-hot");

  a_load_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_cnt_q < n_w)
    else $error("load count reached the vertex count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(reach_row_o)
      && $stable(row_index_o) && $stable(last_row_o)))
    else $error("output beat changed while stalled");

  a_scan_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q == S_SCAN) |-> (CW'(mem_waddr) < n_w))
    else $error("closure write outside the active rows");
`endif

endmodule
